### rtl/core/n2dc_pkg.sv
// ----------------------------------------------------------------------------
// n2dc_pkg
// shared types and constants of the normalised 2-d valid convolution block
// ----------------------------------------------------------------------------
package n2dc_pkg;

	localparam int MaxImageWidth = 256;
	localparam int MaxFilterDim  = 8;
	localparam int TapDepth      = MaxFilterDim * MaxFilterDim;
	localparam int RowDepth      = MaxFilterDim * MaxImageWidth;
	localparam int TapAw         = $clog2(TapDepth);
	localparam int RowAw         = $clog2(RowDepth);
	localparam int ColW          = $clog2(MaxImageWidth);
	localparam int FdW           = $clog2(MaxFilterDim);
	localparam int AccW          = 38;
	localparam int NumW          = 40;
	localparam int SumW          = 22;

	localparam logic [1:0] StOk  = 2'd0;
	localparam logic [1:0] StSat = 2'd1;
	localparam logic [1:0] StBig = 2'd2;

	localparam logic [1:0] RegImgW = 2'd0;
	localparam logic [1:0] RegImgH = 2'd1;
	localparam logic [1:0] RegFltW = 2'd2;
	localparam logic [1:0] RegFltH = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC_RD,
		S_MAC,
		S_DIV_START,
		S_DIV,
		S_OUT
	} seq_state_t;

	// divider handshake
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

### rtl/core/n2dc_div.sv
// ----------------------------------------------------------------------------
// n2dc_div
// radix-2 restoring divider, signed, quotient truncated toward zero
// ----------------------------------------------------------------------------
module n2dc_div
	import n2dc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [NumW-1:0] num,
	input  logic signed [SumW-1:0] den,
	output div_ctl_t               ctl,
	output logic signed [NumW-1:0] quo
);

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] q_q;
	logic [SumW:0]   rem_q;
	logic [SumW-1:0] dmag_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [SumW:0] trial;
	logic [SumW:0] shifted;

	assign shifted = {rem_q[SumW-1:0], q_q[NumW-1]};
	assign trial   = shifted - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= num[NumW-1] ? NumW'(-num) : num;
			dmag_q <= den[SumW-1] ? SumW'(-den) : den;
			neg_q  <= num[NumW-1] ^ den[SumW-1];
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!trial[SumW]) begin
				rem_q <= trial;
				q_q   <= {q_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quo       = neg_q ? -$signed(q_q) : $signed(q_q);
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule

### rtl/core/normalized_2d_valid_convolution.sv
// ----------------------------------------------------------------------------
// normalized_2d_valid_convolution
// filter taps and raster pixels in, normalised window sums out
// ----------------------------------------------------------------------------
// a tap, or a pixel that gives no result, is taken and stored without leaving idle
// a pixel completing a window starts a walk: one shared multiply-accumulate
// walks the taps (read then accumulate), then a 40-step serial divider
// normalises by the tap sum (with a zero tap sum the divider is skipped);
// the result then goes to the output register and the block returns to idle
// output is registered; the next item is taken while a result waits, as long
// as no new result is due
// arst_n clears control state; tap and row stores are undefined until written
module normalized_2d_valid_convolution
	import n2dc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample
	input  logic        s_tuser,  // [0] mode
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [31:0] result, [39:32] out_col, [55:40] out_row
	output logic        m_tlast,  // last
	output logic [1:0]  m_tuser   // [1:0] status
);

	// configuration registers
	logic [8:0]  img_w_q;
	logic [15:0] img_h_q;
	logic [3:0]  flt_w_q;
	logic [3:0]  flt_h_q;

	// progress state
	logic signed [SumW-1:0] tap_sum_q;
	logic [TapAw-1:0]       tap_idx_q;
	logic [ColW-1:0]        pix_col_q;
	logic [15:0]            pix_row_q;

	logic signed [15:0] tap_mem [TapDepth];
	logic signed [15:0] row_mem [RowDepth];

	seq_state_t state_q, state_d;

	// clamped dimensions
	logic [8:0]  w_c;
	logic [15:0] h_c;
	logic [3:0]  fw_c, fh_c;
	logic [6:0]  ntaps;

	always_comb begin
		w_c  = (img_w_q == '0) ? 9'd1 : (img_w_q > 9'(MaxImageWidth)) ?
			9'(MaxImageWidth) : img_w_q;
		h_c  = (img_h_q == '0) ? 16'd1 : img_h_q;
		fw_c = (flt_w_q == '0) ? 4'd1 : (flt_w_q > 4'(MaxFilterDim)) ?
			4'(MaxFilterDim) : flt_w_q;
		fh_c = (flt_h_q == '0) ? 4'd1 : (flt_h_q > 4'(MaxFilterDim)) ?
			4'(MaxFilterDim) : flt_h_q;
		ntaps = 7'(fw_c * fh_c);
	end

	// apb: writes only in the access phase
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			RegImgW: prdata = {23'd0, img_w_q};
			RegImgH: prdata = {16'd0, img_h_q};
			RegFltW: prdata = {28'd0, flt_w_q};
			RegFltH: prdata = {28'd0, flt_h_q};
			default: prdata = '0;
		endcase
	end

	// output register
	logic        out_v_q;
	logic [31:0] res_q;
	logic [7:0]  ocol_q;
	logic [15:0] orow_q;
	logic        olast_q;
	logic [1:0]  ost_q;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {8'd0, orow_q, ocol_q, res_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = ost_q;

	// pixel bookkeeping for the item being taken
	logic [ColW-1:0] col;
	logic [15:0]     row;
	logic            lastpix, fits, win;
	logic            s_fire;

	always_comb begin
		col     = ({1'b0, pix_col_q} >= w_c) ? '0 : pix_col_q;
		row     = (pix_row_q >= h_c) ? '0 : pix_row_q;
		lastpix = ({1'b0, col} == w_c - 9'd1) && (row == h_c - 16'd1);
		fits    = ({5'd0, fw_c} <= w_c) && ({12'd0, fh_c} <= h_c);
		win     = fits && ({1'b0, col} + 9'd1 >= {5'd0, fw_c}) &&
			(17'(row) + 17'd1 >= {13'd0, fh_c});
	end

	// accepted only from idle; a pixel that yields a result also needs a free
	// output register
	assign s_tready = (state_q == S_IDLE) && !cfg_wr &&
		(!s_tuser || !out_v_q || m_tready || !(win || (!fits && lastpix)));
	assign s_fire   = s_tvalid && s_tready;

	// window walk registers
	logic [ColW-1:0] c0_q;
	logic [15:0]     r0_q;
	logic            lastp_q;
	logic [FdW:0]    wi_q, wj_q;
	logic [TapAw-1:0] tix_q;
	logic signed [15:0] tap_rd_s1, pix_rd_s1;
	logic signed [31:0] prod;
	logic signed [AccW-1:0] acc_q;
	logic            rd_last_q;
	logic            mac_done;

	logic [RowAw-1:0] row_addr;
	logic [FdW-1:0]   rsel;
	logic [ColW-1:0]  csel;

	assign rsel     = FdW'(r0_q + 16'(wi_q));
	assign csel     = c0_q + ColW'(wj_q);
	assign row_addr = {rsel, csel};
	assign prod     = tap_rd_s1 * pix_rd_s1;

	// divider
	div_ctl_t dctl;
	logic signed [NumW-1:0] quo;
	logic div_start;

	assign div_start = (state_q == S_DIV_START) && (tap_sum_q != '0);

	n2dc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({acc_q, 2'b00}),
		.den    (tap_sum_q),
		.ctl    (dctl),
		.quo    (quo)
	);

	assign mac_done = rd_last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (s_fire && s_tuser && win) state_d = S_MAC_RD;
			S_MAC_RD:    state_d = S_MAC;
			S_MAC:       if (mac_done) state_d = S_DIV_START;
				else state_d = S_MAC_RD;
			S_DIV_START: state_d = (tap_sum_q != '0) ? S_DIV : S_OUT;
			S_DIV:       if (dctl.done) state_d = S_OUT;
			S_OUT:       state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// saturation of the quotient or of a zero tap sum
	logic [31:0] sat_res;
	logic [1:0]  sat_st;

	always_comb begin
		if (tap_sum_q == '0) begin
			sat_st  = StSat;
			sat_res = (acc_q > 0) ? 32'h7fff_ffff : (acc_q < 0) ? 32'h8000_0000 : '0;
		end else if (quo > NumW'(64'sh7fff_ffff)) begin
			sat_st  = StSat;
			sat_res = 32'h7fff_ffff;
		end else if (quo < -NumW'(64'sh8000_0000)) begin
			sat_st  = StSat;
			sat_res = 32'h8000_0000;
		end else begin
			sat_st  = StOk;
			sat_res = quo[31:0];
		end
	end

	// a new result is loaded from the walk or from an oversize filter frame end
	logic out_set;
	assign out_set = (state_q == S_OUT) || (s_fire && s_tuser && !fits && lastpix);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q   <= 9'd16;
			img_h_q   <= 16'd16;
			flt_w_q   <= 4'd3;
			flt_h_q   <= 4'd3;
			tap_sum_q <= '0;
			tap_idx_q <= '0;
			pix_col_q <= '0;
			pix_row_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_set) out_v_q <= 1'b1;
			else if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					RegImgW: img_w_q <= pwdata[8:0];
					RegImgH: img_h_q <= pwdata[15:0];
					RegFltW: flt_w_q <= pwdata[3:0];
					RegFltH: flt_h_q <= pwdata[3:0];
					default: ;
				endcase
				tap_sum_q <= '0;
				tap_idx_q <= '0;
				pix_col_q <= '0;
				pix_row_q <= '0;
			end else if (s_fire && !s_tuser) begin
				// tap transfer
				if (7'(tap_idx_q) == 7'd0 || 7'(tap_idx_q) >= ntaps)
					tap_sum_q <= SumW'($signed(s_tdata));
				else
					tap_sum_q <= tap_sum_q + SumW'($signed(s_tdata));
				if (7'(tap_idx_q) >= ntaps || 7'(tap_idx_q) + 7'd1 >= ntaps)
					tap_idx_q <= '0;
				else
					tap_idx_q <= tap_idx_q + 1'b1;
			end else if (s_fire) begin
				// pixel transfer
				if ({1'b0, col} + 9'd1 >= w_c) begin
					pix_col_q <= '0;
					pix_row_q <= (17'(row) + 17'd1 >= 17'(h_c)) ? '0 : row + 16'd1;
				end else begin
					pix_col_q <= col + 1'b1;
					pix_row_q <= row;
				end
			end
		end
	end

	// stores and walk datapath
	always_ff @(posedge clk) begin
		if (s_fire && !s_tuser)
			tap_mem[(7'(tap_idx_q) >= ntaps) ? '0 : tap_idx_q] <= s_tdata;
		if (s_fire && s_tuser)
			row_mem[{row[FdW-1:0], col}] <= s_tdata;
		if (state_q == S_MAC_RD) begin
			tap_rd_s1 <= tap_mem[tix_q];
			pix_rd_s1 <= row_mem[row_addr];
			rd_last_q <= (wi_q == (FdW+1)'(fh_c) - 1'b1) &&
				(wj_q == (FdW+1)'(fw_c) - 1'b1);
		end
		if (s_fire && s_tuser) begin
			c0_q    <= ColW'({1'b0, col} + 9'd1 - {5'd0, fw_c});
			r0_q    <= row + 16'd1 - {12'd0, fh_c};
			lastp_q <= lastpix;
			wi_q    <= '0;
			wj_q    <= '0;
			tix_q   <= '0;
			acc_q   <= '0;
		end
		if (state_q == S_MAC_RD) begin
			tix_q <= tix_q + 1'b1;
			if (wj_q == (FdW+1)'(fw_c) - 1'b1) begin
				wj_q <= '0;
				wi_q <= wi_q + 1'b1;
			end else begin
				wj_q <= wj_q + 1'b1;
			end
		end
		if (state_q == S_MAC)
			acc_q <= acc_q + AccW'(prod);
		if (state_q == S_OUT) begin
			res_q   <= sat_res;
			ost_q   <= sat_st;
			ocol_q  <= c0_q;
			orow_q  <= r0_q;
			olast_q <= lastp_q;
		end else if (s_fire && s_tuser && !win && !fits && lastpix) begin
			res_q   <= '0;
			ost_q   <= StBig;
			ocol_q  <= '0;
			orow_q  <= '0;
			olast_q <= 1'b1;
		end
	end

endmodule

### rtl/core/n2dc_checker.sv
// ----------------------------------------------------------------------------
// n2dc_props
// port-level checks of the convolution block
// ----------------------------------------------------------------------------
module n2dc_props
	import n2dc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser,
	input logic        pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_big: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == StBig |-> m_tlast && m_tdata == '0)
		else $error("oversize filter result malformed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("bad status code");

	a_rdy: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind normalized_2d_valid_convolution n2dc_props u_n2dc_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

### test/n2dc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// n2dc_checker
// watches the configuration port and both streams, predicts each normalised
// window sum from the accepted taps and pixels and compares every result
// ----------------------------------------------------------------------------
module n2dc_checker
	import n2dc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  col;
		logic [15:0] row;
		logic        last;
		logic [1:0]  status;
	} window_sum_t;

	window_sum_t sums_due[$];

	logic [8:0]  img_w_reg;
	logic [15:0] img_h_reg;
	logic [3:0]  flt_w_reg, flt_h_reg;
	shortint     taps [TapDepth];
	shortint     rows [RowDepth];
	int          tap_total;
	int unsigned tap_pos, col_pos, row_pos;

	assign pending = sums_due.size();

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned w, h, fw, fh, c0, r0;
		longint      acc, q;
		logic        at_end, fits;
		window_sum_t e, got;
		if (!arst_n) begin
			img_w_reg = 16;
			img_h_reg = 16;
			flt_w_reg = 3;
			flt_h_reg = 3;
			tap_total = 0;
			tap_pos   = 0;
			col_pos   = 0;
			row_pos   = 0;
			fails     = 0;
			sums_due.delete();
		end else begin
			// register write clears filter and frame progress
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					RegImgW: img_w_reg = pwdata[8:0];
					RegImgH: img_h_reg = pwdata[15:0];
					RegFltW: flt_w_reg = pwdata[3:0];
					RegFltH: flt_h_reg = pwdata[3:0];
				endcase
				tap_total = 0;
				tap_pos   = 0;
				col_pos   = 0;
				row_pos   = 0;
			end
			if (s_tvalid && s_tready) begin
				w  = clamp_dim(img_w_reg, MaxImageWidth);
				h  = clamp_dim(img_h_reg, 65535);
				fw = clamp_dim(flt_w_reg, MaxFilterDim);
				fh = clamp_dim(flt_h_reg, MaxFilterDim);
				if (!s_tuser) begin
					if (tap_pos >= fw * fh)
						tap_pos = 0;
					taps[tap_pos] = s_tdata;
					tap_total = (tap_pos == 0) ? int'($signed(s_tdata))
						: tap_total + int'($signed(s_tdata));
					tap_pos++;
					if (tap_pos >= fw * fh)
						tap_pos = 0;
				end else begin
					if (col_pos >= w)
						col_pos = 0;
					if (row_pos >= h)
						row_pos = 0;
					rows[(row_pos % MaxFilterDim) * MaxImageWidth + col_pos] = s_tdata;
					at_end = (col_pos == w - 1) && (row_pos == h - 1);
					fits   = (fw <= w) && (fh <= h);
					if (fits && col_pos + 1 >= fw && row_pos + 1 >= fh) begin
						c0  = col_pos + 1 - fw;
						r0  = row_pos + 1 - fh;
						acc = 0;
						for (int i = 0; i < fh; i++)
							for (int j = 0; j < fw; j++)
								acc += longint'(taps[i * fw + j]) *
									longint'(rows[((r0 + i) % MaxFilterDim) * MaxImageWidth
									+ c0 + j]);
						e.status = StOk;
						if (tap_total == 0) begin
							e.status = StSat;
							q = (acc > 0) ? 64'sd2147483647 :
								((acc < 0) ? -64'sd2147483648 : 0);
						end else begin
							q = (acc * 4) / longint'(tap_total);
							if (q > 64'sd2147483647) begin
								q = 64'sd2147483647;
								e.status = StSat;
							end
							if (q < -64'sd2147483648) begin
								q = -64'sd2147483648;
								e.status = StSat;
							end
						end
						e.value = q[31:0];
						e.col   = c0[7:0];
						e.row   = r0[15:0];
						e.last  = at_end;
						sums_due = {sums_due, e};
					end else if (!fits && at_end) begin
						e = '0;
						e.last   = 1'b1;
						e.status = StBig;
						sums_due = {sums_due, e};
					end
					col_pos++;
					if (col_pos >= w) begin
						col_pos = 0;
						row_pos++;
						if (row_pos >= h)
							row_pos = 0;
					end
				end
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[39:32], m_tdata[55:40], m_tlast, m_tuser};
				if (sums_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result %h", got);
				end else begin
					e = sums_due.pop_front();
					if (got !== e) begin
						fails++;
						if (fails <= 10) begin
							$display("mismatch: expected val %h col %0d row %0d last %b st %0d",
								e.value, e.col, e.row, e.last, e.status);
							$display("          got val %h col %0d row %0d last %b st %0d",
								got.value, got.col, got.row, got.last, got.status);
						end
					end
				end
			end
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives filters and raster frames through the convolution block under many
// register settings, with random idling on both streams; the checker grades
// ----------------------------------------------------------------------------
module testbench;
	import n2dc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [15:0] sample
	logic        s_tuser = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;       // [31:0] result, [39:32] out_col, [55:40] out_row
	logic        m_tlast;       // last
	logic [1:0]  m_tuser;       // [1:0] status

	int  fails, pending;
	int  items_sent = 0;
	bit  quiet = 1'b0;   // no idling in the closing stretch
	int  cycles = 0;
	int  stall_left = 0;

	always #4 clk = ~clk;

	normalized_2d_valid_convolution DUT (.*);

	n2dc_checker checker_i (.*);

	// overall limit, far above the slowest correct run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3000000) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 9);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one transfer on the input stream, then maybe a burst of idle cycles
	task automatic send(input logic mode, input logic [15:0] smp);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// hold off until every result is in, plus room for a pixel still in flight
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic int unsigned eff(int unsigned v, int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// new settings, a complete filter, then a pixel run
	// tap_kind: 0 random, 1 zero sum, 2 small positive
	task automatic run_phase(input int unsigned iw, ih, fw, fh, npix, tap_kind);
		int unsigned ntaps;
		logic [15:0] t, prev;
		drain();
		reg_write(RegImgW, iw);
		reg_write(RegImgH, ih);
		reg_write(RegFltW, fw);
		reg_write(RegFltH, fh);
		ntaps = eff(fw, MaxFilterDim) * eff(fh, MaxFilterDim);
		prev = '0;
		for (int k = 0; k < ntaps; k++) begin
			case (tap_kind)
				1: t = (k % 2) ? -prev : ((k == ntaps - 1) ? 16'h0 : 16'($urandom));
				2: t = 16'($urandom_range(0, 4096));
				default: t = 16'($urandom);
			endcase
			prev = t;
			send(1'b0, t);
		end
		for (int p = 0; p < npix; p++) begin
			// an occasional stray tap mid-frame
			if ($urandom_range(0, 15) == 0)
				send(1'b0, 16'($urandom));
			send(1'b1, 16'($urandom));
		end
	endtask

	initial begin
		int unsigned iw, ih, fw, fh;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero tap sum from extreme taps, extreme pixels
		reg_write(RegImgW, 4);
		reg_write(RegImgH, 3);
		reg_write(RegFltW, 2);
		reg_write(RegFltH, 2);
		send(1'b0, 16'h8000);
		send(1'b0, 16'h7fff);
		send(1'b0, 16'h0000);
		send(1'b0, 16'h0001);
		for (int p = 0; p < 12; p++)
			send(1'b1, (p % 3 == 0) ? 16'h8000 : ((p % 3 == 1) ? 16'h7fff : 16'hffff));
		// tap sum of one drives the quotient into saturation
		drain();
		reg_write(RegImgW, 3);
		reg_write(RegImgH, 1);
		reg_write(RegFltW, 2);
		reg_write(RegFltH, 1);
		send(1'b0, 16'h7fff);
		send(1'b0, 16'h8002);
		send(1'b1, 16'h7fff);
		send(1'b1, 16'h8000);
		send(1'b1, 16'h7fff);
		// filter wider than image
		run_phase(2, 2, 3, 1, 4, 0);
		// zero registers act as one, oversize filter height clamps to eight
		run_phase(0, 0, 0, 15, 3, 2);
		// oversize width clamps to the maximum row
		run_phase(511, 1, 1, 1, 256, 2);
		// tallest frame, tall filter
		run_phase(4, 65535, 2, 8, 40, 0);
		// largest filter
		run_phase(9, 9, 8, 8, 81, 1);

		while (items_sent < 540) begin
			iw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(1, 10);
			ih = $urandom_range(0, 6);
			fw = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4);
			fh = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 3);
			if (items_sent > 500)
				quiet = 1'b1;
			run_phase(iw, ih, fw, fh,
				eff(iw, MaxImageWidth) * eff(ih, 65535) * $urandom_range(1, 2),
				$urandom_range(0, 2));
		end

		quiet = 1'b1;
		drain();
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
